>>> hdl/daa_pkg.sv
// daa_pkg: constants, types and arctangent table for the directed arc angle core
// depends on nothing
`default_nettype none
package daa_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CORDIC_STAGES = 16;
    localparam int GUARD_BITS = 16;
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    // vector grows by ~1.65 plus sign, keep margin
    localparam int VEC_WIDTH = DIFF_WIDTH + GUARD_BITS + 3;
    localparam int ANG_WIDTH = ANGLE_FRAC_BITS + 5;
    localparam int ARC_WIDTH = 16;
    localparam int SH = 30 - ANGLE_FRAC_BITS;

    typedef logic signed [DIFF_WIDTH-1:0] diff_t;
    typedef logic signed [VEC_WIDTH-1:0] vec_t;
    typedef logic signed [ANG_WIDTH-1:0] ang_t;

    typedef struct packed {
        vec_t x;
        vec_t y;
        ang_t z;
    } lane_state_t;

    function automatic ang_t fmt(input longint q30);
        longint r;
        r = (q30 + (64'sd1 <<< (SH - 1))) >>> SH;
        return ang_t'(r);
    endfunction

    function automatic longint atan_q30(input int i);
        longint v;
        case (i)
            0: v = 843314857;
            1: v = 497837830;
            2: v = 263043837;
            3: v = 133525159;
            4: v = 67021687;
            5: v = 33543516;
            6: v = 16775851;
            7: v = 8388437;
            8: v = 4194283;
            9: v = 2097149;
            default: v = (i < 31) ? (64'sd1 <<< (30 - i)) : 64'sd0;
        endcase
        return v;
    endfunction

    localparam ang_t PI_A = fmt(64'sd3373259426);
    localparam ang_t TWO_PI_A = fmt(64'sd6746518852);
endpackage
`default_nettype wire

>>> hdl/daa_lane.sv
// daa_lane: pipelined cordic vectoring atan2 for one point about the center
// depends on daa_pkg
`default_nettype none
module daa_lane (
    input  wire logic clk,
    input  wire logic en,
    input  wire daa_pkg::diff_t dx,
    input  wire daa_pkg::diff_t dy,
    output daa_pkg::ang_t angle
);
    import daa_pkg::*;

    lane_state_t st_reg [CORDIC_STAGES+1];
    logic        zero_reg [CORDIC_STAGES+1];
    lane_state_t st_next;
    lane_state_t st_nx [CORDIC_STAGES];
    logic        neg;

    always_comb
    begin
        neg = dx[DIFF_WIDTH-1];
        st_next.x = neg ? vec_t'(-dx) <<< GUARD_BITS : vec_t'(dx) <<< GUARD_BITS;
        st_next.y = neg ? vec_t'(-dy) <<< GUARD_BITS : vec_t'(dy) <<< GUARD_BITS;
        st_next.z = !neg ? ang_t'(0) : (dy[DIFF_WIDTH-1] ? -PI_A : PI_A);
    end

    // one vectoring iteration per stage
    always_comb
    begin
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            st_nx[i] = st_reg[i];
            if (!st_reg[i].y[VEC_WIDTH-1])
            begin
                st_nx[i].x = st_reg[i].x + (st_reg[i].y >>> i);
                st_nx[i].y = st_reg[i].y - (st_reg[i].x >>> i);
                st_nx[i].z = st_reg[i].z + fmt(atan_q30(i));
            end
            else
            begin
                st_nx[i].x = st_reg[i].x - (st_reg[i].y >>> i);
                st_nx[i].y = st_reg[i].y + (st_reg[i].x >>> i);
                st_nx[i].z = st_reg[i].z - fmt(atan_q30(i));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]   <= st_next;
            zero_reg[0] <= (dx == '0) && (dy == '0);
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                st_reg[i+1]   <= st_nx[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    assign angle = zero_reg[CORDIC_STAGES] ? ang_t'(0) : st_reg[CORDIC_STAGES].z;
endmodule
`default_nettype wire

>>> hdl/daa_merge.sv
// daa_merge: directed difference of the two lane angles, wrap and saturate
// depends on daa_pkg
`default_nettype none
module daa_merge (
    input  wire daa_pkg::ang_t alpha,
    input  wire daa_pkg::ang_t beta,
    input  wire logic ccw,
    output logic [daa_pkg::ARC_WIDTH-1:0] arc
);
    import daa_pkg::*;

    logic signed [ANG_WIDTH+1:0] d;
    logic signed [ANG_WIDTH+1:0] tp;

    always_comb
    begin
        tp = (ANG_WIDTH+2)'(TWO_PI_A);
        d = ccw ? ((ANG_WIDTH+2)'(beta) - (ANG_WIDTH+2)'(alpha))
                : ((ANG_WIDTH+2)'(alpha) - (ANG_WIDTH+2)'(beta));
        if (d <= 0)
            d = d + tp;
        if (d < 0)
            d = '0;
        if (d > tp)
            d = tp;
        arc = d[ARC_WIDTH-1:0];
    end
endmodule
`default_nettype wire

>>> hdl/directed_arc_angle_core.sv
// directed_arc_angle_core: swept arc between two points on a circle
// depends on daa_pkg, daa_lane, daa_merge
//
// usage: one input channel (center, from, to, direction_ccw) with
// in_valid/in_ready and one output channel (arc_angle) with
// out_valid/out_ready. each accepted transaction gives one result.
// two cordic lanes find the start and end angles side by side, one
// vectoring iteration per pipeline stage, and a merge stage forms the arc.
// a result passes the lane stages and the output register before out_valid;
// throughput is one transaction per cycle while the output is not stalled.
// the whole pipeline advances only while the output register is empty
// or being taken, so a stalled receiver freezes it with no loss.
// reset clears all valid bits; the pipeline payload is not reset.
`default_nettype none
module directed_arc_angle_core (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic signed [daa_pkg::COORD_WIDTH-1:0] center_x,
    input  wire logic signed [daa_pkg::COORD_WIDTH-1:0] center_y,
    input  wire logic signed [daa_pkg::COORD_WIDTH-1:0] from_x,
    input  wire logic signed [daa_pkg::COORD_WIDTH-1:0] from_y,
    input  wire logic signed [daa_pkg::COORD_WIDTH-1:0] to_x,
    input  wire logic signed [daa_pkg::COORD_WIDTH-1:0] to_y,
    input  wire logic direction_ccw,
    output logic out_valid,
    input  wire logic out_ready,
    output logic [daa_pkg::ARC_WIDTH-1:0] arc_angle
);
    import daa_pkg::*;

    localparam int DEPTH = CORDIC_STAGES + 1;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] ccw_reg;
    logic             out_valid_reg;
    logic [ARC_WIDTH-1:0] arc_reg;
    logic             en;
    ang_t             alpha, beta;
    logic [ARC_WIDTH-1:0] arc_next;
    diff_t fdx, fdy, tdx, tdy;

    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign fdx = diff_t'(from_x) - diff_t'(center_x);
    assign fdy = diff_t'(from_y) - diff_t'(center_y);
    assign tdx = diff_t'(to_x) - diff_t'(center_x);
    assign tdy = diff_t'(to_y) - diff_t'(center_y);

    daa_lane u_from (.clk(clk), .en(en), .dx(fdx), .dy(fdy), .angle(alpha));
    daa_lane u_to   (.clk(clk), .en(en), .dx(tdx), .dy(tdy), .angle(beta));

    daa_merge u_merge (.alpha(alpha), .beta(beta), .ccw(ccw_reg[DEPTH-1]), .arc(arc_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[DEPTH-2:0], in_valid};
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ccw_reg <= {ccw_reg[DEPTH-2:0], direction_ccw};
            arc_reg <= arc_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign arc_angle = arc_reg;
endmodule
`default_nettype wire

>>> dv/tb_directed_arc_angle_core.sv
// tb_directed_arc_angle_core: self-checking bench for the directed arc angle core
// depends on daa_pkg and directed_arc_angle_core; predicts each arc with its own
// fixed-point cordic model and checks results in order under random stalls
`default_nettype none
module tb_directed_arc_angle_core;
    import daa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = CORDIC_STAGES + 20;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [COORD_WIDTH-1:0] center_x, center_y, from_x, from_y, to_x, to_y;
    logic direction_ccw;
    logic out_valid;
    logic out_ready;
    logic [ARC_WIDTH-1:0] arc_angle;

    logic [ARC_WIDTH-1:0] expected_arcs[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int idle_cycles = 0;
    int rx_hold = 0;
    bit hold_receiver = 0;
    bit sender_gaps = 1;
    bit receiver_gaps = 1;

    directed_arc_angle_core DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .center_x(center_x), .center_y(center_y), .from_x(from_x), .from_y(from_y),
        .to_x(to_x), .to_y(to_y), .direction_ccw(direction_ccw),
        .out_valid(out_valid), .out_ready(out_ready), .arc_angle(arc_angle)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint round_angle(input longint q30);
        return (q30 + (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
    endfunction

    function automatic longint arctan_q30(input int i);
        longint tbl[10] = '{843314857, 497837830, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
            return tbl[i];
        if (i < 31)
            return 64'sd1 <<< (30 - i);
        return 0;
    endfunction

    function automatic longint point_angle(input longint dx, input longint dy);
        longint x, y, z, xs, ys;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        if (dx < 0)
        begin
            z = (dy >= 0) ? round_angle(64'sd3373259426) : -round_angle(64'sd3373259426);
            dx = -dx;
            dy = -dy;
        end
        x = dx <<< GUARD_BITS;
        y = dy <<< GUARD_BITS;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + round_angle(arctan_q30(i));
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - round_angle(arctan_q30(i));
            end
        end
        return z;
    endfunction

    function automatic logic [ARC_WIDTH-1:0] swept_arc(
        input logic signed [COORD_WIDTH-1:0] cx, cy, fx, fy, tx, ty, input logic ccw);
        longint two_pi, a, b, d;
        two_pi = round_angle(64'sd6746518852);
        a = point_angle(longint'(fx) - longint'(cx), longint'(fy) - longint'(cy));
        b = point_angle(longint'(tx) - longint'(cx), longint'(ty) - longint'(cy));
        d = ccw ? (b - a) : (a - b);
        if (d <= 0)
            d += two_pi;
        if (d < 0)
            d = 0;
        if (d > two_pi)
            d = two_pi;
        return d[ARC_WIDTH-1:0];
    endfunction

    task automatic send_query(input int cx, cy, fx, fy, tx, ty, input int ccw);
        int gap;
        logic signed [COORD_WIDTH-1:0] qcx, qcy, qfx, qfy, qtx, qty;
        qcx = COORD_WIDTH'(cx);
        qcy = COORD_WIDTH'(cy);
        qfx = COORD_WIDTH'(fx);
        qfy = COORD_WIDTH'(fy);
        qtx = COORD_WIDTH'(tx);
        qty = COORD_WIDTH'(ty);
        gap = 0;
        if (sender_gaps)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0)
                gap = 0;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        center_x <= qcx;
        center_y <= qcy;
        from_x <= qfx;
        from_y <= qfy;
        to_x <= qtx;
        to_y <= qty;
        direction_ccw <= ccw[0];
        in_valid <= 1'b1;
        expected_arcs.push_back(swept_arc(qcx, qcy, qfx, qfy, qtx, qty, ccw[0]));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return COORD_WIDTH'(int'($urandom_range(0, 15)) - 8);
            1: return COORD_WIDTH'(int'($urandom_range(0, 1023)) - 512);
            default: return COORD_WIDTH'($urandom);
        endcase
    endfunction

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold <= 0;
        end
        else if (hold_receiver)
            out_ready <= 1'b0;
        else if (!receiver_gaps)
            out_ready <= 1'b1;
        else if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else if ($urandom_range(0, 49) == 0)
        begin
            out_ready <= 1'b0;
            rx_hold <= $urandom_range(5, 30);
        end
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        logic [ARC_WIDTH-1:0] want;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
                $display("FAIL directed_arc_angle_core");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                received++;
                if (expected_arcs.size() == 0)
                begin
                    $display("%0t unexpected result arc_angle=%0d", $time, arc_angle);
                    errors++;
                end
                else
                begin
                    want = expected_arcs.pop_front();
                    if (arc_angle !== want)
                    begin
                        $display("%0t arc_angle mismatch: expected %0d actual %0d",
                                 $time, want, arc_angle);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic test_directed();
        logic signed [COORD_WIDTH-1:0] mx, mn;
        mx = 16'sh7fff;
        mn = 16'sh8000;
        send_query(0, 0, 0, 0, 0, 0, 1);
        send_query(0, 0, 0, 0, 0, 0, 0);
        send_query(0, 0, 16, 0, 0, 16, 1);
        send_query(0, 0, 16, 0, 0, 16, 0);
        send_query(0, 0, 16, 0, 16, 0, 1);
        send_query(0, 0, -16, 0, -16, 1, 1);
        send_query(0, 0, -16, 0, -16, -1, 1);
        send_query(0, 0, -16, 0, -16, -1, 0);
        send_query(0, 0, 0, -16, 0, 16, 1);
        send_query(mn, mn, mx, mx, mn, mx, 1);
        send_query(mx, mx, mn, mn, mx, mn, 0);
        send_query(mx, mn, mn, mx, mx, mx, 1);
        send_query(mn, mx, mx, mn, mn, mn, 0);
        send_query(mx, mx, mx, mx, mn, mn, 1);
        send_query(0, 0, mn, 0, mx, 0, 1);
        send_query(0, 0, 0, mn, 0, mx, 0);
        send_query(5, 5, 5, 5, 100, -3, 1);
        send_query(-3, 7, 10, 7, -3, 7, 0);
        send_query(0, 0, 1, -1, 1, 1, 0);
        send_query(0, 0, -1, -1, -1, 1, 1);
    endtask

    task automatic test_random();
        for (int n = 0; n < 1200; n++)
        begin
            if (n == 400)
                sender_gaps = 0;
            if (n == 700)
                sender_gaps = 1;
            receiver_gaps = !(n >= 500 && n < 650);
            send_query(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), $urandom_range(0, 1));
        end
    endtask

    task automatic test_backpressure();
        sender_gaps = 0;
        fork
            begin
                hold_receiver = 1;
                repeat (200) @(posedge clk);
                hold_receiver = 0;
            end
            for (int n = 0; n < 150; n++)
                send_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(0, 1));
        join
        sender_gaps = 1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        center_x = '0;
        center_y = '0;
        from_x = '0;
        from_y = '0;
        to_x = '0;
        to_y = '0;
        direction_ccw = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        in_valid <= 1'b0;
        while (expected_arcs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d arc queries (edge points, full turns, random), checked %0d arcs",
                 sent, received);
        $display("including a long receiver stall and back-to-back input");
        if (errors == 0)
            $display("PASS directed_arc_angle_core");
        else
            $display("FAIL directed_arc_angle_core");
        $finish;
    end
endmodule
`default_nettype wire
